// ===== design/brf_pkg.sv =====
// shared types and codes for the byte ring fifo with drain
// no dependencies; imported by every design file and the checker
package brf_pkg;

    localparam int SIZE_DEF = 64;
    localparam int POS_W    = 6;
    localparam int DATA_W   = 8;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;

    // operation codes, also used as the classified command kind
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
    localparam logic [OP_W-1:0] OP_READ   = 3'd1;
    localparam logic [OP_W-1:0] OP_DRAIN  = 3'd2;
    localparam logic [OP_W-1:0] OP_PEEK   = 3'd3;
    localparam logic [OP_W-1:0] OP_STATUS = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   kind;
        logic [DATA_W-1:0] data;
        logic [POS_W-1:0]  stop;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_slot_t;

endpackage

// ===== design/brf_front.sv =====
// front end: takes commands, folds unused op codes into status, queues them
// depends on brf_pkg
module brf_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [brf_pkg::OP_W-1:0]   op,
    input  logic [brf_pkg::DATA_W-1:0] data_in,
    input  logic [brf_pkg::POS_W-1:0]  stop_index,
    output logic                    busy,
    output brf_pkg::cmd_slot_t      head_cmd,
    input  logic                    pop
);
    import brf_pkg::*;

    localparam int QD = 2;

    cmd_t       q_mem [QD];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       do_pop;
    cmd_t       in_cmd;

    always_comb
    begin
        in_cmd.data = data_in;
        in_cmd.stop = stop_index;
        if (op > OP_STATUS)
        begin
            in_cmd.kind = OP_STATUS;
        end
        else
        begin
            in_cmd.kind = op;
        end
    end

    assign busy   = (count_reg == 2'(QD));
    assign push   = start && !busy;
    assign do_pop = pop && (count_reg != 2'd0);

    assign head_cmd.valid = (count_reg != 2'd0);
    assign head_cmd.cmd   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/brf_back.sv =====
// back end: ring storage, head and tail positions, drain sequencer, result register
// depends on brf_pkg; fed by brf_front
module brf_back #(
    parameter int SIZE = brf_pkg::SIZE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  brf_pkg::cmd_slot_t         head_cmd,
    output logic                       pop,
    output logic                       done,
    output logic [brf_pkg::DATA_W-1:0] data_out,
    output logic                       data_valid,
    output logic [brf_pkg::ST_W-1:0]   status,
    output logic                       last,
    output logic [brf_pkg::POS_W-1:0]  drain_count,
    output logic [brf_pkg::POS_W-1:0]  head_now,
    output logic [brf_pkg::POS_W-1:0]  tail_now
);
    import brf_pkg::*;

    localparam int PW = (SIZE > 2) ? $clog2(SIZE) : 1;
    localparam logic [PW-1:0] LAST_POS = PW'(SIZE - 1);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_DRAIN = 1'b1;

    logic [DATA_W-1:0] mem [SIZE];

    logic              state_reg;
    logic              state_next;
    logic [PW-1:0]     head_reg;
    logic [PW-1:0]     head_next;
    logic [PW-1:0]     tail_reg;
    logic [PW-1:0]     tail_next;
    logic [POS_W-1:0]  stop_reg;
    logic [POS_W-1:0]  stop_next;
    logic [POS_W-1:0]  cnt_reg;
    logic [POS_W-1:0]  cnt_next;

    logic              done_reg;
    logic              done_next;
    logic              dv_reg;
    logic              dv_next;
    logic [ST_W-1:0]   st_reg;
    logic [ST_W-1:0]   st_next;
    logic              last_reg;
    logic              last_next;
    logic [POS_W-1:0]  cnt_out_reg;
    logic [POS_W-1:0]  cnt_out_next;
    logic [DATA_W-1:0] rd_data_reg;

    logic              take;
    logic              q_empty;
    logic              q_full;
    logic [PW-1:0]     head_step;
    logic [PW-1:0]     head_prev;
    logic [PW-1:0]     tail_step;
    logic [POS_W-1:0]  dr_stop;
    logic [POS_W-1:0]  dr_cnt;
    logic              dr_dry;
    logic              dr_hit;
    logic              mem_we;
    logic              rd_en;
    logic [PW-1:0]     rd_addr;

    assign take = (state_reg == S_IDLE) && head_cmd.valid;
    assign pop  = take;

    assign head_step = (head_reg == LAST_POS) ? '0 : head_reg + 1'b1;
    assign head_prev = (head_reg == '0) ? LAST_POS : head_reg - 1'b1;
    assign tail_step = (tail_reg == LAST_POS) ? '0 : tail_reg + 1'b1;
    assign q_empty   = (head_reg == tail_reg);
    assign q_full    = (head_step == tail_reg);

    // one drain pop: the first comes straight from the command, the rest from the loop
    assign dr_stop = take ? head_cmd.cmd.stop : stop_reg;
    assign dr_cnt  = take ? POS_W'(1) : cnt_reg + 1'b1;
    assign dr_dry  = (head_reg == tail_step);
    assign dr_hit  = (POS_W'(tail_step) == dr_stop);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        stop_next    = stop_reg;
        cnt_next     = cnt_reg;
        done_next    = 1'b0;
        dv_next      = 1'b0;
        st_next      = ST_OK;
        last_next    = 1'b1;
        cnt_out_next = '0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = tail_reg;

        if (state_reg == S_DRAIN)
        begin
            done_next    = 1'b1;
            rd_en        = 1'b1;
            tail_next    = tail_step;
            dv_next      = 1'b1;
            cnt_out_next = dr_cnt;
            cnt_next     = dr_cnt;
            last_next    = dr_dry || dr_hit;
            st_next      = dr_dry ? ST_EMPTY : ST_OK;
            if (dr_dry || dr_hit)
            begin
                state_next = S_IDLE;
            end
        end
        else if (take)
        begin
            done_next = 1'b1;
            unique case (head_cmd.cmd.kind)
                OP_WRITE:
                begin
                    if (q_full)
                    begin
                        st_next = ST_FULL;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        head_next = head_step;
                    end
                end
                OP_READ:
                begin
                    if (q_empty)
                    begin
                        st_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        tail_next = tail_step;
                        dv_next   = 1'b1;
                    end
                end
                OP_DRAIN:
                begin
                    if (q_empty)
                    begin
                        st_next = ST_EMPTY;
                    end
                    else if (POS_W'(tail_reg) != head_cmd.cmd.stop)
                    begin
                        rd_en        = 1'b1;
                        tail_next    = tail_step;
                        dv_next      = 1'b1;
                        cnt_out_next = dr_cnt;
                        cnt_next     = dr_cnt;
                        stop_next    = head_cmd.cmd.stop;
                        last_next    = dr_dry || dr_hit;
                        st_next      = dr_dry ? ST_EMPTY : ST_OK;
                        if (!(dr_dry || dr_hit))
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                end
                OP_PEEK:
                begin
                    if (q_empty)
                    begin
                        st_next = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = head_prev;
                        dv_next = 1'b1;
                        st_next = q_full ? ST_FULL : ST_OK;
                    end
                end
                default:
                begin
                    st_next = q_empty ? ST_EMPTY : (q_full ? ST_FULL : ST_OK);
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[head_reg] <= head_cmd.cmd.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        dv_reg      <= dv_next;
        st_reg      <= st_next;
        last_reg    <= last_next;
        cnt_out_reg <= cnt_out_next;
        stop_reg    <= stop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // positions are read live from the ring registers and already reflect the operation
    assign done        = done_reg;
    assign data_out    = dv_reg ? rd_data_reg : '0;
    assign data_valid  = dv_reg;
    assign status      = st_reg;
    assign last        = last_reg;
    assign drain_count = cnt_out_reg;
    assign head_now    = POS_W'(head_reg);
    assign tail_now    = POS_W'(tail_reg);

endmodule

// ===== design/byte_ring_fifo_with_drain.sv =====
// channel   signals                                 handshake
// command   op, data_in, stop_index                 start high while busy low
// result    data_out, data_valid, status, last,     done high for one cycle
//           drain_count, head_now, tail_now
//
// write, read, peek and status give one result, in the cycle after the command
// leaves the two-entry command queue; they run one a cycle while no drain runs
// a drain gives one result a cycle, one per byte popped, from the single
// storage read port; the queue fills behind it and busy rises when it is full
// reset clears positions, queue and sequencer; storage contents are not cleared
// results cannot be held off by the receiver
//
// top level; depends on brf_pkg, brf_front, brf_back
module byte_ring_fifo_with_drain #(
    parameter int SIZE = brf_pkg::SIZE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [brf_pkg::OP_W-1:0]   op,
    input  logic [brf_pkg::DATA_W-1:0] data_in,
    input  logic [brf_pkg::POS_W-1:0]  stop_index,
    output logic                       done,
    output logic [brf_pkg::DATA_W-1:0] data_out,
    output logic                       data_valid,
    output logic [brf_pkg::ST_W-1:0]   status,
    output logic                       last,
    output logic [brf_pkg::POS_W-1:0]  drain_count,
    output logic [brf_pkg::POS_W-1:0]  head_now,
    output logic [brf_pkg::POS_W-1:0]  tail_now
);
    import brf_pkg::*;

    cmd_slot_t head_cmd;
    logic      pop;

    brf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .op         (op),
        .data_in    (data_in),
        .stop_index (stop_index),
        .busy       (busy),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    brf_back #(
        .SIZE (SIZE)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .done        (done),
        .data_out    (data_out),
        .data_valid  (data_valid),
        .status      (status),
        .last        (last),
        .drain_count (drain_count),
        .head_now    (head_now),
        .tail_now    (tail_now)
    );

endmodule

// ===== design/brf_checker.sv =====
// port-level checks on the result stream of the byte ring fifo
// depends on brf_pkg; bound to byte_ring_fifo_with_drain below
module brf_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       done,
    input logic [brf_pkg::DATA_W-1:0] data_out,
    input logic                       data_valid,
    input logic [brf_pkg::ST_W-1:0]   status,
    input logic                       last,
    input logic [brf_pkg::POS_W-1:0]  drain_count,
    input logic [brf_pkg::POS_W-1:0]  head_now,
    input logic [brf_pkg::POS_W-1:0]  tail_now
);
    import brf_pkg::*;

    // a beat without a byte shows zero data
    a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !data_valid) |-> (data_out == '0))
        else $error("data_out not zero on a beat without a byte");

    // mid-drain beats always carry a byte with status ok
    a_mid_drain_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |-> (data_valid && status == ST_OK))
        else $error("non-final beat without byte or with bad status");

    // drain beats follow back to back with a rising count
    a_drain_run: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !last) |=> (done && drain_count == $past(drain_count) + 1'b1))
        else $error("drain beats not contiguous or count out of step");

    // a popped byte reported with status empty leaves head and tail equal
    a_dry_positions: assert property (@(posedge clk) disable iff (!rst_n)
        (done && data_valid && status == ST_EMPTY) |-> (head_now == tail_now))
        else $error("empty status with head and tail apart");

endmodule

bind byte_ring_fifo_with_drain brf_checker u_brf_checker (.*);
